FILE: rtl/spe_pkg.sv
// Shared types, constants and elaboration-time table functions for the
// sinusoidal position encoding core. No dependencies.
package spe_pkg;

	localparam int REG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int SLOT_W    = 13;
	localparam int PAIR_W    = 11;
	localparam int STATUS_W  = 2;
	localparam int MAG_W     = 13;

	localparam int MAX_FRAMES    = 4096;
	localparam int OUT_BITS      = 16;
	localparam int CORDIC_STAGES = 16;

	// Divider for the exponent: numerator is 2*i*log2(10000) in Q24.
	localparam int NUM_W    = 40;
	localparam int T_W      = 28;
	localparam int FRAC_W   = 24;
	localparam int EXP_W    = 4;
	localparam int DIV_STEP = 4;
	localparam int DIV_STAGES = T_W / DIV_STEP;
	localparam logic [28:0] TWO_LOG2_TEN_K_Q24 = 29'd445861642;

	localparam int M_W    = 31;
	localparam int PROD_W = 44;

	// Phase reduction modulo two pi.
	localparam int MOD_Q_BITS = 12;
	localparam int MOD_STEP   = 2;
	localparam int MOD_STAGES = MOD_Q_BITS / MOD_STEP;
	localparam int PHASE_W    = 33;
	localparam logic [PHASE_W-1:0] TWO_PI_Q30  = 33'd6746518852;
	localparam logic [PHASE_W-1:0] HALF_PI_Q30 = 33'd1686629713;
	localparam logic [31:0] ONE_Q30        = 32'd1073741824;
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
	localparam logic [63:0] QUARTER_PI_Q30 = 64'd843314857;

	localparam int XW = 34;
	localparam int ZW = 33;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_FRAMES = 2'd1,
		ST_ODD    = 2'd2,
		ST_RANGE  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HIDDEN_WIDTH  = 2'd0,
		REG_FRAME_COUNT   = 2'd1,
		REG_MAX_POSITIONS = 2'd2
	} reg_idx_t;

	typedef struct packed {
		status_t            status;
		logic               neg;
		logic [MAG_W-1:0]   mag;
	} meta_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bw;
		logic [63:0] rem;
		rem = v;
		res = '0;
		bw  = 64'h4000000000000000;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bw) begin
				rem = rem - (res + bw);
				res = (res >> 1) + bw;
			end else begin
				res = res >> 1;
			end
			bw = bw >> 2;
		end
		return res;
	endfunction

	// Restoring long division; only evaluated while building the constant tables.
	function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= d) begin
				r    = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Q30 value of 2^(-2^-k), built as a chain of floor square roots.
	function automatic logic [63:0] inv_const(input int k);
		logic [63:0] c;
		c = isqrt64(64'd1 << 59);
		for (int j = 1; j < k; j++) begin
			c = isqrt64(c << 30);
		end
		return c;
	endfunction

	// atan(2^-k) in Q30 from the alternating series summed in Q62.
	function automatic logic [63:0] atan_q30(input int k);
		logic [63:0] sum;
		logic [63:0] term;
		logic        add;
		logic        done;
		int          sh;
		sum  = '0;
		add  = 1'b1;
		done = 1'b0;
		if (k == 0) begin
			return QUARTER_PI_Q30;
		end
		for (int n = 1; n < 64; n += 2) begin
			sh = k * n;
			if (sh >= 62) begin
				done = 1'b1;
			end
			if (!done) begin
				term = udiv64(64'd1 << (62 - sh), 64'(n));
				sum  = add ? sum + term : sum - term;
				add  = !add;
			end
		end
		return (sum + (64'd1 << 31)) >> 32;
	endfunction

endpackage

FILE: rtl/spe_if.sv
// Request and result channel interfaces of the position encoding core.
// Depends on spe_pkg for field widths and the status type.
interface spe_req_if;
	import spe_pkg::*;
	logic               valid;
	logic               ready;
	logic [SLOT_W-1:0]  slot;
	logic [PAIR_W-1:0]  pair_index;
	modport source (output valid, output slot, output pair_index, input ready);
	modport sink (input valid, input slot, input pair_index, output ready);
endinterface

interface spe_rsp_if #(
	parameter int OUT_BITS = spe_pkg::OUT_BITS
);
	import spe_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] sine_value;
	logic signed [OUT_BITS-1:0] cosine_value;
	logic [STATUS_W-1:0]        status;
	modport source (output valid, output sine_value, output cosine_value, output status,
		input ready);
	modport sink (input valid, input sine_value, input cosine_value, input status,
		output ready);
endinterface

FILE: rtl/sinusoidal_position_encoding_core.sv
// Sinusoidal position encoding core: pipelined exponent, phase reduction and CORDIC.
// Depends on spe_pkg and the spe_req_if / spe_rsp_if interfaces.

// One request (slot, pair_index) yields one result: sine and cosine of
// (frame_count-1-slot) * 10000^(-2*pair_index/hidden_width) in signed fixed
// point, plus a status code; on any error both values are zero. The core takes
// one item every cycle while its skid buffer is empty, through one input
// stage, seven radix-16 divider stages for the exponent, twenty-four stages
// of the fractional power product, one phase multiply, six stages of modulo
// two pi, one quadrant stage, one stage per CORDIC rotation and one output
// stage. The one-entry skid buffer behind the output holds the finished item
// when the result side stalls and halts the pipeline while full. Registers may
// only be written while no item is in flight; there is no clearing pass.
module sinusoidal_position_encoding_core #(
	parameter int OUT_BITS      = spe_pkg::OUT_BITS,
	parameter int CORDIC_STAGES = spe_pkg::CORDIC_STAGES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [spe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spe_pkg::REG_W-1:0]      cfg_data,
	spe_req_if.sink                        req,
	spe_rsp_if.source                      rsp
);
	import spe_pkg::*;

	typedef struct packed {
		logic [REG_W-1:0] rem;
		logic [T_W-1:0]   low;
		logic [T_W-1:0]   q;
		meta_t            meta;
	} dv_t;

	typedef struct packed {
		logic [M_W-1:0]    m;
		logic [FRAC_W-1:0] f;
		logic [EXP_W-1:0]  n;
		meta_t             meta;
	} iv_t;

	typedef struct packed {
		logic [PROD_W-1:0] prod;
		meta_t             meta;
	} pm_t;

	typedef struct packed {
		logic [PHASE_W-1:0]    rem;
		logic [MOD_Q_BITS-1:0] low;
		meta_t                 meta;
	} md_t;

	typedef struct packed {
		logic [1:0]    quad;
		logic [ZW-1:0] z;
		meta_t         meta;
	} qd_t;

	typedef struct packed {
		logic [XW-1:0] x;
		logic [XW-1:0] y;
		logic [ZW-1:0] z;
		logic [1:0]    quad;
		meta_t         meta;
	} cd_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] sin;
		logic [OUT_BITS-1:0] cos;
		status_t             st;
	} rsp_t;

	localparam int SH_DN = (OUT_BITS <= 31) ? 31 - OUT_BITS : 0;
	localparam int SH_UP = (OUT_BITS > 31) ? OUT_BITS - 31 : 0;
	localparam logic signed [63:0] RND    = (64'sd1 <<< SH_DN) >>> 1;
	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (OUT_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

	logic [REG_W-1:0] hidden_q, frames_q, maxpos_q;
	logic             en;
	logic             skid_v_q;
	rsp_t             skid_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hidden_q <= 13'd512;
			frames_q <= 13'd1;
			maxpos_q <= 13'd4096;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HIDDEN_WIDTH:  hidden_q <= cfg_data;
				REG_FRAME_COUNT:   frames_q <= cfg_data;
				REG_MAX_POSITIONS: maxpos_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en        = !skid_v_q;
	assign req.ready = en;

	// Stage 1: checks, signed distance and exponent numerator.
	logic              frames_bad, range_bad, neg_c;
	logic [14:0]       slot_p2;
	meta_t             meta_c;
	logic              v_s1;
	meta_t             meta_s1;
	logic [NUM_W-1:0]  num_s1;

	always_comb begin
		frames_bad = (frames_q > maxpos_q) || ({4'b0, frames_q} > 17'(MAX_FRAMES));
		slot_p2    = {2'b0, req.slot} + 15'd2;
		range_bad  = (slot_p2 > {1'b0, frames_q, 1'b0})
			|| ({1'b0, req.pair_index} >= hidden_q[REG_W-1:1]);
		neg_c      = ({1'b0, req.slot} + 14'd1) > {1'b0, frames_q};
		if (frames_bad) begin
			meta_c.status = ST_FRAMES;
		end else if (hidden_q[0]) begin
			meta_c.status = ST_ODD;
		end else if (range_bad) begin
			meta_c.status = ST_RANGE;
		end else begin
			meta_c.status = ST_OK;
		end
		meta_c.neg = neg_c;
		meta_c.mag = neg_c ? 13'(req.slot + 13'd1 - frames_q)
			: 13'(frames_q - 13'd1 - req.slot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && req.valid) begin
			meta_s1 <= meta_c;
			num_s1  <= {29'd0, req.pair_index} * {11'd0, TWO_LOG2_TEN_K_Q24};
		end
	end

	// Exponent t = numerator / hidden_width, four quotient bits per stage.
	dv_t  dv_s   [DIV_STAGES];
	logic dv_v_s [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		dv_t  src_w, nxt_w;
		logic src_v;
		if (g == 0) begin : g_first
			always_comb begin
				src_w.rem  = {1'b0, num_s1[NUM_W-1:T_W]};
				src_w.low  = num_s1[T_W-1:0];
				src_w.q    = '0;
				src_w.meta = meta_s1;
			end
			assign src_v = v_s1;
		end else begin : g_next
			assign src_w = dv_s[g-1];
			assign src_v = dv_v_s[g-1];
		end
		always_comb begin
			logic [REG_W:0] r;
			nxt_w = src_w;
			for (int b = 0; b < DIV_STEP; b++) begin
				r         = {nxt_w.rem, nxt_w.low[T_W-1]};
				nxt_w.low = nxt_w.low << 1;
				if (r >= {1'b0, hidden_q}) begin
					nxt_w.rem = REG_W'(r - {1'b0, hidden_q});
					nxt_w.q   = {nxt_w.q[T_W-2:0], 1'b1};
				end else begin
					nxt_w.rem = r[REG_W-1:0];
					nxt_w.q   = {nxt_w.q[T_W-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[g] <= 1'b0;
			end else if (en) begin
				dv_v_s[g] <= src_v;
			end
		end
		always_ff @(posedge clk) begin
			if (en && src_v) begin
				dv_s[g] <= nxt_w;
			end
		end
	end

	// 2^-f as a product of one rounded Q30 factor per set fraction bit.
	iv_t  iv_s   [FRAC_W];
	logic iv_v_s [FRAC_W];

	for (genvar g = 0; g < FRAC_W; g++) begin : g_inv
		localparam logic [29:0] FACTOR = 30'(inv_const(g + 1));
		iv_t  src_w, nxt_w;
		logic src_v;
		if (g == 0) begin : g_first
			always_comb begin
				src_w.m    = M_W'(ONE_Q30);
				src_w.f    = dv_s[DIV_STAGES-1].q[FRAC_W-1:0];
				src_w.n    = dv_s[DIV_STAGES-1].q[T_W-1:FRAC_W];
				src_w.meta = dv_s[DIV_STAGES-1].meta;
			end
			assign src_v = dv_v_s[DIV_STAGES-1];
		end else begin : g_next
			assign src_w = iv_s[g-1];
			assign src_v = iv_v_s[g-1];
		end
		always_comb begin
			logic [60:0] p;
			nxt_w = src_w;
			p     = {30'd0, src_w.m} * {31'd0, FACTOR} + 61'(64'd1 << 29);
			if (src_w.f[FRAC_W-1-g]) begin
				nxt_w.m = p[60:30];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				iv_v_s[g] <= 1'b0;
			end else if (en) begin
				iv_v_s[g] <= src_v;
			end
		end
		always_ff @(posedge clk) begin
			if (en && src_v) begin
				iv_s[g] <= nxt_w;
			end
		end
	end

	// Inverse frequency times distance.
	pm_t  pm_s1;
	logic pm_v_s1;
	logic [M_W-1:0] inv_w;

	assign inv_w = iv_s[FRAC_W-1].m >> iv_s[FRAC_W-1].n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_v_s1 <= 1'b0;
		end else if (en) begin
			pm_v_s1 <= iv_v_s[FRAC_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en && iv_v_s[FRAC_W-1]) begin
			pm_s1.prod <= {31'd0, iv_s[FRAC_W-1].meta.mag} * {13'd0, inv_w};
			pm_s1.meta <= iv_s[FRAC_W-1].meta;
		end
	end

	// Phase modulo two pi, two restoring steps per stage.
	md_t  md_s   [MOD_STAGES];
	logic md_v_s [MOD_STAGES];

	for (genvar g = 0; g < MOD_STAGES; g++) begin : g_mod
		md_t  src_w, nxt_w;
		logic src_v;
		if (g == 0) begin : g_first
			always_comb begin
				src_w.rem  = {1'b0, pm_s1.prod[PROD_W-1:MOD_Q_BITS]};
				src_w.low  = pm_s1.prod[MOD_Q_BITS-1:0];
				src_w.meta = pm_s1.meta;
			end
			assign src_v = pm_v_s1;
		end else begin : g_next
			assign src_w = md_s[g-1];
			assign src_v = md_v_s[g-1];
		end
		always_comb begin
			logic [PHASE_W:0] r;
			nxt_w = src_w;
			for (int b = 0; b < MOD_STEP; b++) begin
				r         = {nxt_w.rem, nxt_w.low[MOD_Q_BITS-1]};
				nxt_w.low = nxt_w.low << 1;
				if (r >= {1'b0, TWO_PI_Q30}) begin
					nxt_w.rem = PHASE_W'(r - {1'b0, TWO_PI_Q30});
				end else begin
					nxt_w.rem = r[PHASE_W-1:0];
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				md_v_s[g] <= 1'b0;
			end else if (en) begin
				md_v_s[g] <= src_v;
			end
		end
		always_ff @(posedge clk) begin
			if (en && src_v) begin
				md_s[g] <= nxt_w;
			end
		end
	end

	// Quadrant and residual angle in [0, pi/2).
	qd_t  qd_s1, qd_c;
	logic qd_v_s1;
	logic [PHASE_W-1:0] ph_w;

	assign ph_w = md_s[MOD_STAGES-1].rem;

	always_comb begin
		qd_c.meta = md_s[MOD_STAGES-1].meta;
		if (ph_w >= 33'(3 * HALF_PI_Q30)) begin
			qd_c.quad = 2'd3;
			qd_c.z    = ZW'(ph_w - 33'(3 * HALF_PI_Q30));
		end else if (ph_w >= 33'(2 * HALF_PI_Q30)) begin
			qd_c.quad = 2'd2;
			qd_c.z    = ZW'(ph_w - 33'(2 * HALF_PI_Q30));
		end else if (ph_w >= HALF_PI_Q30) begin
			qd_c.quad = 2'd1;
			qd_c.z    = ZW'(ph_w - HALF_PI_Q30);
		end else begin
			qd_c.quad = 2'd0;
			qd_c.z    = ZW'(ph_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qd_v_s1 <= 1'b0;
		end else if (en) begin
			qd_v_s1 <= md_v_s[MOD_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en && md_v_s[MOD_STAGES-1]) begin
			qd_s1 <= qd_c;
		end
	end

	// CORDIC rotation, one micro-rotation per stage.
	cd_t  cd_s   [CORDIC_STAGES];
	logic cd_v_s [CORDIC_STAGES];

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		localparam logic [ZW-1:0] ANGLE = ZW'(atan_q30(g));
		cd_t  src_w, nxt_w;
		logic src_v;
		if (g == 0) begin : g_first
			always_comb begin
				src_w.x    = XW'(CORDIC_GAIN_Q30);
				src_w.y    = '0;
				src_w.z    = qd_s1.z;
				src_w.quad = qd_s1.quad;
				src_w.meta = qd_s1.meta;
			end
			assign src_v = qd_v_s1;
		end else begin : g_next
			assign src_w = cd_s[g-1];
			assign src_v = cd_v_s[g-1];
		end
		always_comb begin
			logic signed [XW-1:0] dx;
			logic signed [XW-1:0] dy;
			dx    = $signed(src_w.y) >>> g;
			dy    = $signed(src_w.x) >>> g;
			nxt_w = src_w;
			if (!src_w.z[ZW-1]) begin
				nxt_w.x = src_w.x - dx;
				nxt_w.y = src_w.y + dy;
				nxt_w.z = src_w.z - ANGLE;
			end else begin
				nxt_w.x = src_w.x + dx;
				nxt_w.y = src_w.y - dy;
				nxt_w.z = src_w.z + ANGLE;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cd_v_s[g] <= 1'b0;
			end else if (en) begin
				cd_v_s[g] <= src_v;
			end
		end
		always_ff @(posedge clk) begin
			if (en && src_v) begin
				cd_s[g] <= nxt_w;
			end
		end
	end

	// Quadrant fold-back, sign of the distance and output rounding with saturation.
	function automatic logic [OUT_BITS-1:0] to_out(input logic signed [XW:0] v);
		logic signed [63:0] r;
		r = ((64'(v) + RND) >>> SH_DN) <<< SH_UP;
		if (r > SAT_HI) begin
			r = SAT_HI;
		end else if (r < SAT_LO) begin
			r = SAT_LO;
		end
		return r[OUT_BITS-1:0];
	endfunction

	cd_t  cf_w;
	rsp_t op_c, op_s1;
	logic op_v_s1;

	assign cf_w = cd_s[CORDIC_STAGES-1];

	always_comb begin
		logic signed [XW:0] xs;
		logic signed [XW:0] ys;
		logic signed [XW:0] s;
		logic signed [XW:0] c;
		xs = (XW+1)'($signed(cf_w.x));
		ys = (XW+1)'($signed(cf_w.y));
		case (cf_w.quad)
			2'd0: begin s = ys;  c = xs;  end
			2'd1: begin s = xs;  c = -ys; end
			2'd2: begin s = -ys; c = -xs; end
			default: begin s = -xs; c = ys; end
		endcase
		if (cf_w.meta.neg) begin
			s = -s;
		end
		op_c.st = cf_w.meta.status;
		if (cf_w.meta.status == ST_OK) begin
			op_c.sin = to_out(s);
			op_c.cos = to_out(c);
		end else begin
			op_c.sin = '0;
			op_c.cos = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_v_s1 <= 1'b0;
		end else if (en) begin
			op_v_s1 <= cd_v_s[CORDIC_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en && cd_v_s[CORDIC_STAGES-1]) begin
			op_s1 <= op_c;
		end
	end

	// The skid entry catches the finished item when the result side stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (!skid_v_q && op_v_s1 && !rsp.ready) begin
			skid_v_q <= 1'b1;
		end else if (skid_v_q && rsp.ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && op_v_s1 && !rsp.ready) begin
			skid_q <= op_s1;
		end
	end

	rsp_t rsp_w;
	assign rsp_w            = skid_v_q ? skid_q : op_s1;
	assign rsp.valid        = skid_v_q | op_v_s1;
	assign rsp.sine_value   = rsp_w.sin;
	assign rsp.cosine_value = rsp_w.cos;
	assign rsp.status       = rsp_w.st;

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.sine_value == '0 && rsp.cosine_value == '0)
		else $error("error item carries nonzero values");

	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !rsp.ready |=> skid_v_q && $stable(skid_q))
		else $error("skid entry lost or changed while stalled");

	a_residual: assert property (@(posedge clk) disable iff (!arst_n)
		qd_v_s1 |-> qd_s1.z < ZW'(HALF_PI_Q30))
		else $error("residual angle outside the first quadrant");
`endif

endmodule
